@@ rtl/core/gvsd_pkg.sv @@
// Package for the GARCH volatility spike detector: word types, register
// indexes, reset values and widths. It depends on nothing else.
package gvsd_pkg;

  localparam int COUNT_WIDTH = 32;

  localparam int MCAND_W  = 96;
  localparam int MPLIER_W = 48;
  localparam int ACC_W    = MCAND_W + MPLIER_W;
  localparam int MCNT_W   = 6;

  localparam int DIVD_W   = 53;
  localparam int DCNT_W   = 6;

  localparam int SQ_W     = 60;
  localparam int ROOT_W   = 30;
  localparam int SCNT_W   = 5;

  typedef struct packed {
    logic              mode;
    logic signed [47:0] sample;
  } in_word_t;

  typedef struct packed {
    logic [29:0]        sigma;
    logic [59:0]        variance;
    logic signed [47:0] innovation;
    logic               spike;
    logic [31:0]        spike_count;
    logic [31:0]        sample_count;
  } out_word_t;

  typedef enum logic [2:0] {
    REG_OMEGA       = 3'd0,
    REG_ALPHA       = 3'd1,
    REG_BETA        = 3'd2,
    REG_INIT_VAR    = 3'd3,
    REG_WARMUP      = 3'd4,
    REG_SPIKE_RATIO = 3'd5
  } reg_index_t;

  localparam logic [59:0] OMEGA_RESET    = 60'd1099512;
  localparam logic [31:0] ALPHA_RESET    = 32'd429496730;
  localparam logic [31:0] BETA_RESET     = 32'd3650722202;
  localparam logic [59:0] INIT_VAR_RESET = 60'd109951163;
  localparam logic [15:0] WARMUP_RESET   = 16'd10;
  localparam logic [31:0] RATIO_RESET    = 32'd33554432;
  localparam logic [29:0] PSIG_RESET     = 30'd10485;

  localparam logic [59:0] VAR_MIN  = 60'd110;
  localparam logic [59:0] VAR_MAX  = 60'd1099511627776000000;
  localparam logic [71:0] TERM_CAP = 72'd1 << 62;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

endpackage

@@ rtl/core/garch_volatility_spike_detector.sv @@
// Top level of the GARCH(1,1) volatility spike detector. It sequences the
// serial divider, multiplier and square root units. Uses gvsd_pkg.
//
// Usage: each input word carries a mode bit and a signed Q16.32 sample.
// Mode 0 updates the running mean, the GARCH variance, sigma and the spike
// test; mode 1 reloads the state from the initial variance register. Every
// input word yields exactly one output word with sigma, variance, innovation,
// the spike flag and both counts.
// A sample word passes through the divide by twenty in the mean update, the
// squaring of the innovation, the alpha and beta products, the square root
// and the ratio product, in that order, before its output word is ready. A
// clear word uses only the square root unit. One word is worked on at a
// time, so no new word is accepted until the last one has been passed to
// the output register. A new word is taken while the previous result waits
// in the output register. If the receiver stalls, the finished result holds
// until the output register frees and no further word is accepted.
// Reset loads the register defaults and the cleared state; configuration
// writes take effect at once and are to be made by the user only while the
// block is idle; the block itself does not enforce this.
module garch_volatility_spike_detector (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gvsd_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gvsd_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [59:0]         cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_SQ, S_AM, S_BM, S_SQRT, S_RM, S_CLR, S_OUT
  } state_t;

  localparam int CW = gvsd_pkg::COUNT_WIDTH;

  state_t state_r;

  logic [59:0] omega_r, iv_r;
  logic [31:0] alpha_r, beta_r, ratio_r;
  logic [15:0] warmup_r;

  logic signed [47:0] mean_r;
  logic [59:0]        var_r;
  logic [29:0]        psig_r;
  logic [CW-1:0]      scnt_r, kcnt_r;

  logic [47:0] x_r;
  logic        neg_r;
  logic [47:0] eps_r;
  logic [62:0] aterm_r;
  logic [59:0] vnew_r;
  logic [29:0] sigma_r;

  gvsd_pkg::out_word_t res_r, out_r;
  logic                out_valid_r;

  logic accept;

  logic [53:0] mean_ext, x_ext, sum, mag;
  logic [52:0] dividend;
  logic [47:0] mean_new;
  logic [48:0] eps49;
  logic [47:0] eps_sat, e_abs;
  logic [71:0] p56;
  logic [62:0] aterm;
  logic [59:0] bterm;
  logic [63:0] var64;
  logic [59:0] var_clamp;
  logic [61:0] lhs;
  logic        spike_hit;
  logic [CW-1:0] scnt_new, kcnt_new;

  logic                          div_start, div_done;
  logic [gvsd_pkg::DIVD_W-1:0]    div_q;
  logic                          mul_start, mul_done;
  logic [gvsd_pkg::MCAND_W-1:0]   mul_mcand;
  logic [gvsd_pkg::MPLIER_W-1:0]  mul_mplier;
  logic [gvsd_pkg::MCNT_W-1:0]    mul_nbits;
  logic [gvsd_pkg::ACC_W-1:0]     mul_acc;
  logic                          sq_start, sq_done;
  logic [gvsd_pkg::SQ_W-1:0]      sq_value;
  logic [gvsd_pkg::ROOT_W-1:0]    sq_root;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    mean_ext = {{6{mean_r[47]}}, mean_r};
    x_ext    = {{6{in_data.sample[47]}}, in_data.sample};
    sum      = (mean_ext << 4) + (mean_ext << 1) + mean_ext + x_ext;
    mag      = sum[53] ? (~sum + 54'd1) : sum;
    dividend = mag[52:0] + 53'd10;

    mean_new = neg_r ? (~div_q[47:0] + 48'd1) : div_q[47:0];
    eps49    = {x_r[47], x_r} - {mean_new[47], mean_new};
    if (!eps49[48] && eps49[47]) begin
      eps_sat = {1'b0, {47{1'b1}}};
    end else if (eps49[48] && !eps49[47]) begin
      eps_sat = {1'b1, 47'd0};
    end else begin
      eps_sat = eps49[47:0];
    end
    e_abs = eps_sat[47] ? (~eps_sat + 48'd1) : eps_sat;

    p56   = mul_acc[143:72];
    aterm = (p56 > gvsd_pkg::TERM_CAP) ? gvsd_pkg::TERM_CAP[62:0] : p56[62:0];

    bterm = mul_acc[107:48];
    var64 = {4'd0, omega_r} + {1'b0, aterm_r} + {4'd0, bterm};
    if (var64 < {4'd0, gvsd_pkg::VAR_MIN}) begin
      var_clamp = gvsd_pkg::VAR_MIN;
    end else if (var64 > {4'd0, gvsd_pkg::VAR_MAX}) begin
      var_clamp = gvsd_pkg::VAR_MAX;
    end else begin
      var_clamp = var64[59:0];
    end

    lhs       = {8'd0, sigma_r, 24'd0};
    spike_hit = (scnt_r >= CW'(warmup_r)) && (psig_r != '0) && (lhs > mul_acc[79:18]);
    kcnt_new  = (spike_hit && kcnt_r != gvsd_pkg::CNT_MAX) ? kcnt_r + CW'(1) : kcnt_r;
    scnt_new  = (scnt_r != gvsd_pkg::CNT_MAX) ? scnt_r + CW'(1) : scnt_r;
  end

  always_comb begin
    div_start  = accept && !in_data.mode;
    sq_start   = 1'b0;
    sq_value   = iv_r;
    mul_start  = 1'b0;
    mul_mcand  = '0;
    mul_mplier = '0;
    mul_nbits  = '0;
    case (state_r)
      S_IDLE: begin
        sq_start = accept && in_data.mode;
      end
      S_DIV: begin
        mul_start  = div_done;
        mul_mcand  = gvsd_pkg::MCAND_W'(e_abs);
        mul_mplier = e_abs;
        mul_nbits  = gvsd_pkg::MCNT_W'(48);
      end
      S_SQ: begin
        mul_start  = mul_done;
        mul_mcand  = mul_acc[95:0];
        mul_mplier = gvsd_pkg::MPLIER_W'(alpha_r);
        mul_nbits  = gvsd_pkg::MCNT_W'(32);
      end
      S_AM: begin
        mul_start  = mul_done;
        mul_mcand  = gvsd_pkg::MCAND_W'(var_r);
        mul_mplier = gvsd_pkg::MPLIER_W'(beta_r);
        mul_nbits  = gvsd_pkg::MCNT_W'(32);
      end
      S_BM: begin
        sq_start = mul_done;
        sq_value = var_clamp;
      end
      S_SQRT: begin
        mul_start  = sq_done;
        mul_mcand  = gvsd_pkg::MCAND_W'(ratio_r);
        mul_mplier = gvsd_pkg::MPLIER_W'(psig_r);
        mul_nbits  = gvsd_pkg::MCNT_W'(30);
      end
      default: begin
      end
    endcase
  end

  gvsd_div20 u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .done     (div_done),
    .quotient (div_q)
  );

  gvsd_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mul_mcand),
    .mplier (mul_mplier),
    .nbits  (mul_nbits),
    .done   (mul_done),
    .acc    (mul_acc)
  );

  gvsd_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value (sq_value),
    .done  (sq_done),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      omega_r     <= gvsd_pkg::OMEGA_RESET;
      alpha_r     <= gvsd_pkg::ALPHA_RESET;
      beta_r      <= gvsd_pkg::BETA_RESET;
      iv_r        <= gvsd_pkg::INIT_VAR_RESET;
      warmup_r    <= gvsd_pkg::WARMUP_RESET;
      ratio_r     <= gvsd_pkg::RATIO_RESET;
      mean_r      <= '0;
      var_r       <= gvsd_pkg::INIT_VAR_RESET;
      psig_r      <= gvsd_pkg::PSIG_RESET;
      scnt_r      <= '0;
      kcnt_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gvsd_pkg::REG_OMEGA:       omega_r  <= cfg_wdata;
          gvsd_pkg::REG_ALPHA:       alpha_r  <= cfg_wdata[31:0];
          gvsd_pkg::REG_BETA:        beta_r   <= cfg_wdata[31:0];
          gvsd_pkg::REG_INIT_VAR:    iv_r     <= cfg_wdata;
          gvsd_pkg::REG_WARMUP:      warmup_r <= cfg_wdata[15:0];
          gvsd_pkg::REG_SPIKE_RATIO: ratio_r  <= cfg_wdata[31:0];
          default: begin
          end
        endcase
      end

      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            x_r     <= in_data.sample;
            neg_r   <= sum[53];
            state_r <= in_data.mode ? S_CLR : S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            mean_r  <= mean_new;
            eps_r   <= eps_sat;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          if (mul_done) begin
            state_r <= S_AM;
          end
        end
        S_AM: begin
          if (mul_done) begin
            aterm_r <= aterm;
            state_r <= S_BM;
          end
        end
        S_BM: begin
          if (mul_done) begin
            vnew_r  <= var_clamp;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            sigma_r <= sq_root;
            state_r <= S_RM;
          end
        end
        S_RM: begin
          if (mul_done) begin
            var_r              <= vnew_r;
            psig_r             <= sigma_r;
            scnt_r             <= scnt_new;
            kcnt_r             <= kcnt_new;
            res_r.sigma        <= sigma_r;
            res_r.variance     <= vnew_r;
            res_r.innovation   <= eps_r;
            res_r.spike        <= spike_hit;
            res_r.spike_count  <= 32'(kcnt_new);
            res_r.sample_count <= 32'(scnt_new);
            state_r            <= S_OUT;
          end
        end
        S_CLR: begin
          if (sq_done) begin
            mean_r             <= '0;
            var_r              <= iv_r;
            psig_r             <= sq_root;
            scnt_r             <= '0;
            kcnt_r             <= '0;
            res_r.sigma        <= sq_root;
            res_r.variance     <= iv_r;
            res_r.innovation   <= '0;
            res_r.spike        <= 1'b0;
            res_r.spike_count  <= '0;
            res_r.sample_count <= '0;
            state_r            <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_r       <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/core/gvsd_mul.sv @@
// Serial-parallel multiplier: one multiplier bit per cycle, product in the
// accumulator after nbits steps, shifted up by MPLIER_W - nbits. Uses gvsd_pkg.
module gvsd_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [gvsd_pkg::MCAND_W-1:0]  mcand,
  input  logic [gvsd_pkg::MPLIER_W-1:0] mplier,
  input  logic [gvsd_pkg::MCNT_W-1:0]   nbits,
  output logic                         done,
  output logic [gvsd_pkg::ACC_W-1:0]    acc
);

  logic [gvsd_pkg::MCAND_W-1:0] mcand_r;
  logic [gvsd_pkg::ACC_W-1:0]   acc_r;
  logic [gvsd_pkg::MCNT_W-1:0]  cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic [gvsd_pkg::MCAND_W:0]   sum;

  always_comb begin
    sum = {1'b0, acc_r[gvsd_pkg::ACC_W-1:gvsd_pkg::MPLIER_W]} +
          (acc_r[0] ? {1'b0, mcand_r} : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == gvsd_pkg::MCNT_W'(1));
      if (start) begin
        busy_r  <= 1'b1;
        cnt_r   <= nbits;
        mcand_r <= mcand;
        acc_r   <= {{gvsd_pkg::MCAND_W{1'b0}}, mplier};
      end else if (busy_r) begin
        acc_r <= {sum, acc_r[gvsd_pkg::MPLIER_W-1:1]};
        cnt_r <= cnt_r - gvsd_pkg::MCNT_W'(1);
        if (cnt_r == gvsd_pkg::MCNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign acc  = acc_r;

endmodule

@@ rtl/core/gvsd_div20.sv @@
// Restoring divider by twenty, one quotient bit per cycle.
// Uses gvsd_pkg for widths.
module gvsd_div20 (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [gvsd_pkg::DIVD_W-1:0]  dividend,
  output logic                        done,
  output logic [gvsd_pkg::DIVD_W-1:0]  quotient
);

  logic [gvsd_pkg::DIVD_W-1:0] q_r;
  logic [4:0]                 rem_r;
  logic [gvsd_pkg::DCNT_W-1:0] cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [5:0]                 trial;
  logic                       ge;

  always_comb begin
    trial = {rem_r, q_r[gvsd_pkg::DIVD_W-1]};
    ge    = trial >= 6'd20;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == gvsd_pkg::DCNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= gvsd_pkg::DCNT_W'(gvsd_pkg::DIVD_W);
        q_r    <= dividend;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? 5'(trial - 6'd20) : trial[4:0];
        q_r   <= {q_r[gvsd_pkg::DIVD_W-2:0], ge};
        cnt_r <= cnt_r - gvsd_pkg::DCNT_W'(1);
        if (cnt_r == gvsd_pkg::DCNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

@@ rtl/core/gvsd_sqrt.sv @@
// Digit-by-digit integer square root, one root bit per cycle.
// Uses gvsd_pkg for widths.
module gvsd_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [gvsd_pkg::SQ_W-1:0]   value,
  output logic                       done,
  output logic [gvsd_pkg::ROOT_W-1:0] root
);

  logic [gvsd_pkg::SQ_W-1:0]   v_r;
  logic [gvsd_pkg::SQ_W-1:0]   r_r;
  logic [gvsd_pkg::SQ_W-1:0]   bit_r;
  logic [gvsd_pkg::SCNT_W-1:0] cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [gvsd_pkg::SQ_W:0]     trial;
  logic                       ge;

  always_comb begin
    trial = {1'b0, r_r} + {1'b0, bit_r};
    ge    = {1'b0, v_r} >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == gvsd_pkg::SCNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= gvsd_pkg::SCNT_W'(gvsd_pkg::ROOT_W);
        v_r    <= value;
        r_r    <= '0;
        bit_r  <= gvsd_pkg::SQ_W'(1) << (gvsd_pkg::SQ_W - 2);
      end else if (busy_r) begin
        if (ge) begin
          v_r <= v_r - trial[gvsd_pkg::SQ_W-1:0];
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - gvsd_pkg::SCNT_W'(1);
        if (cnt_r == gvsd_pkg::SCNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign root = r_r[gvsd_pkg::ROOT_W-1:0];

endmodule

@@ tb/gvsd_checker.sv @@
// Checker for the GARCH volatility spike detector: watches the input, result and
// configuration ports, predicts each result word and compares it field by field.
// Depends on gvsd_pkg.
module gvsd_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  gvsd_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  gvsd_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [59:0]         cfg_wdata,
  output int                  fail_count,
  output int                  pending_count,
  output int                  spike_total,
  output int                  word_total
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [59:0] omega_r, init_var_r;
  logic [31:0] alpha_r, beta_r, ratio_r;
  logic [15:0] warmup_r;
  logic signed [47:0] mean_st;
  logic [59:0] var_st;
  logic [29:0] psig_st;
  logic [gvsd_pkg::COUNT_WIDTH-1:0] samples_st, spikes_st;
  gvsd_pkg::out_word_t expected_words[$];

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void load_cleared();
    mean_st = 0;
    var_st = init_var_r;
    psig_st = 30'(int_sqrt({4'd0, init_var_r}));
    samples_st = 0;
    spikes_st = 0;
  endfunction

  function automatic gvsd_pkg::out_word_t predict_garch(input gvsd_pkg::in_word_t w);
    gvsd_pkg::out_word_t r;
    logic signed [63:0] x, s, m, e;
    logic [63:0] mag, sig;
    logic [127:0] sq;
    logic [191:0] ap;
    logic [127:0] at, bt;
    logic [127:0] v;
    r = '0;
    if (w.mode) begin
      load_cleared();
      r.sigma = psig_st;
      r.variance = var_st;
      return r;
    end
    x = w.sample;
    s = 19 * 64'(mean_st) + x;
    if (s >= 0) m = (s + 10) / 20;
    else m = -((-s + 10) / 20);
    mean_st = m[47:0];
    e = x - m;
    if (e > 64'sh7FFFFFFFFFFF) e = 64'sh7FFFFFFFFFFF;
    if (e < -64'sh800000000000) e = -64'sh800000000000;
    mag = (e < 0) ? 64'(-e) : 64'(e);
    sq = 128'(mag) * 128'(mag);
    ap = 192'(sq) * 192'(alpha_r);
    at = 128'(ap >> 56);
    if (at > (128'd1 << 62)) at = 128'd1 << 62;
    bt = (128'(beta_r) * 128'(var_st)) >> 32;
    v = 128'(omega_r) + at + bt;
    if (v < 128'(gvsd_pkg::VAR_MIN)) v = 128'(gvsd_pkg::VAR_MIN);
    if (v > 128'(gvsd_pkg::VAR_MAX)) v = 128'(gvsd_pkg::VAR_MAX);
    var_st = v[59:0];
    sig = int_sqrt({4'd0, var_st});
    if (32'(samples_st) >= 32'(warmup_r) && psig_st != 0 &&
        (128'(sig) << 24) > 128'(ratio_r) * 128'(psig_st)) begin
      r.spike = 1'b1;
      if (spikes_st != gvsd_pkg::CNT_MAX) spikes_st++;
    end
    psig_st = sig[29:0];
    if (samples_st != gvsd_pkg::CNT_MAX) samples_st++;
    r.sigma = sig[29:0];
    r.variance = var_st;
    r.innovation = e[47:0];
    r.spike_count = 32'(spikes_st);
    r.sample_count = 32'(samples_st);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  always @(posedge clk) begin
    gvsd_pkg::out_word_t ex;
    if (!rst_n) begin
      omega_r = gvsd_pkg::OMEGA_RESET;
      alpha_r = gvsd_pkg::ALPHA_RESET;
      beta_r = gvsd_pkg::BETA_RESET;
      init_var_r = gvsd_pkg::INIT_VAR_RESET;
      warmup_r = gvsd_pkg::WARMUP_RESET;
      ratio_r = gvsd_pkg::RATIO_RESET;
      load_cleared();
      expected_words.delete();
      fail_count = 0;
      spike_total = 0;
      word_total = 0;
    end else begin
      if (cfg_we) begin
        case (gvsd_pkg::reg_index_t'(cfg_index))
          gvsd_pkg::REG_OMEGA:       omega_r = cfg_wdata;
          gvsd_pkg::REG_ALPHA:       alpha_r = cfg_wdata[31:0];
          gvsd_pkg::REG_BETA:        beta_r = cfg_wdata[31:0];
          gvsd_pkg::REG_INIT_VAR:    init_var_r = cfg_wdata;
          gvsd_pkg::REG_WARMUP:      warmup_r = cfg_wdata[15:0];
          gvsd_pkg::REG_SPIKE_RATIO: ratio_r = cfg_wdata[31:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        word_total++;
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", 64'(out_data.sigma), 64'd0);
        end else begin
          ex = expected_words.pop_front();
          if (out_data.spike) spike_total++;
          if (out_data.sigma !== ex.sigma)
            report_mismatch("sigma", 64'(out_data.sigma), 64'(ex.sigma));
          if (out_data.variance !== ex.variance)
            report_mismatch("variance", 64'(out_data.variance), 64'(ex.variance));
          if (out_data.innovation !== ex.innovation)
            report_mismatch("innovation", 64'(out_data.innovation), 64'(ex.innovation));
          if (out_data.spike !== ex.spike)
            report_mismatch("spike", 64'(out_data.spike), 64'(ex.spike));
          if (out_data.spike_count !== ex.spike_count)
            report_mismatch("spike_count", 64'(out_data.spike_count),
                            64'(ex.spike_count));
          if (out_data.sample_count !== ex.sample_count)
            report_mismatch("sample_count", 64'(out_data.sample_count),
                            64'(ex.sample_count));
        end
      end
      if (in_valid && in_ready) expected_words.push_back(predict_garch(in_data));
    end
    pending_count = expected_words.size();
  end
endmodule

@@ tb/tb_top.sv @@
// Top of the testbench for the GARCH volatility spike detector: clock, reset,
// stimulus, register phases and verdict. Uses gvsd_pkg and gvsd_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  gvsd_pkg::in_word_t in_data;
  gvsd_pkg::out_word_t out_data;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [59:0] cfg_wdata;
  int fail_count, pending_count, spike_total, word_total;
  int send_idle_pct, stall_pct;
  bit hold_off;
  int idle_cycles;

  garch_volatility_spike_detector DUT (.*);
  gvsd_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d words pending", pending_count);
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_word(input logic mode, input logic [47:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{mode: mode, sample: value};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(input gvsd_pkg::reg_index_t idx, input logic [59:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [47:0] random_sample(input int shape);
    logic [47:0] v;
    v = 48'({$urandom, $urandom});
    case (shape)
      0: v = 48'($signed(v[35:0]));
      1: v = 48'($signed(v[23:0]));
      default: ;
    endcase
    return v;
  endfunction

  task automatic run_samples(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(39) == 0) send_word(1'b1, random_sample(2));
      else send_word(1'b0, random_sample($urandom_range(3)));
    end
  endtask

  initial begin
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_wdata = 0;
    hold_off = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    rst_n = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: field extremes, clears and a sudden jump after warm-up.
    send_word(1'b0, 48'h7FFFFFFFFFFF);
    send_word(1'b0, 48'h800000000000);
    send_word(1'b0, 48'h0);
    send_word(1'b1, 48'hFFFFFFFFFFFF);
    for (int i = 0; i < 12; i++) send_word(1'b0, 48'h100);
    send_word(1'b0, 48'h7FFFFFFFFFFF);
    send_word(1'b0, 48'h800000000000);
    send_word(1'b1, 48'h0);
    drain();

    write_reg(gvsd_pkg::REG_OMEGA, 60'd0);
    write_reg(gvsd_pkg::REG_INIT_VAR, 60'd0);
    write_reg(gvsd_pkg::REG_WARMUP, 60'd0);
    write_reg(gvsd_pkg::REG_SPIKE_RATIO, 60'd0);
    write_reg(gvsd_pkg::REG_ALPHA, 60'hFFFFFFFF);
    write_reg(gvsd_pkg::REG_BETA, 60'd0);
    send_word(1'b1, 48'h0);
    send_word(1'b0, 48'h0);
    send_word(1'b0, 48'h7FFFFFFFFFFF);
    send_word(1'b0, 48'h1);
    drain();

    write_reg(gvsd_pkg::REG_OMEGA, 60'd1099511627776000000);
    write_reg(gvsd_pkg::REG_INIT_VAR, 60'd1099511627776000000);
    write_reg(gvsd_pkg::REG_BETA, 60'hFFFFFFFF);
    write_reg(gvsd_pkg::REG_SPIKE_RATIO, 60'hFFFFFFFF);
    write_reg(gvsd_pkg::REG_WARMUP, 60'hFFFF);
    send_word(1'b1, 48'h0);
    run_samples(20);
    drain();

    // Receiver holds off while the sender keeps offering words.
    write_reg(gvsd_pkg::REG_OMEGA, 60'd1099512);
    write_reg(gvsd_pkg::REG_ALPHA, 60'd429496730);
    write_reg(gvsd_pkg::REG_BETA, 60'd3650722202);
    write_reg(gvsd_pkg::REG_INIT_VAR, 60'd110);
    write_reg(gvsd_pkg::REG_WARMUP, 60'd3);
    write_reg(gvsd_pkg::REG_SPIKE_RATIO, 60'd20000000);
    send_word(1'b1, 48'h0);
    fork
      begin
        hold_off = 1;
        repeat (2000) @(posedge clk);
        hold_off = 0;
      end
      run_samples(10);
    join
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 9 : 56) : 0;
      stall_pct = (ph == 2) ? 56 : ((ph == 3) ? 9 : 0);
      write_reg(gvsd_pkg::REG_ALPHA, 60'($urandom));
      write_reg(gvsd_pkg::REG_BETA, 60'({1'b1, 31'($urandom)}));
      write_reg(gvsd_pkg::REG_OMEGA, 60'($urandom_range(1 << 24)));
      write_reg(gvsd_pkg::REG_INIT_VAR, 60'($urandom) + 60'd110);
      write_reg(gvsd_pkg::REG_WARMUP, 60'($urandom_range(20)));
      write_reg(gvsd_pkg::REG_SPIKE_RATIO, 60'($urandom_range(40000000, 16777216)));
      send_word(1'b1, 48'h0);
      run_samples(160);
      drain();
    end

    $display("run covered %0d result words across register extremes and idle phases,",
             word_total);
    $display("with %0d spikes and a long receiver hold-off", spike_total);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
